// ===== hw/rtl/stb_pkg.sv =====
// shared types and constants for the software timer bank
`default_nettype none

package stb_pkg;

  localparam int unsigned NumTimersDef  = 16;
  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned CmdW          = 3;
  localparam int unsigned SlotW         = 4;
  localparam int unsigned DurW          = 32;
  localparam int unsigned StatusW       = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK    = 3'd0,
    CMD_INIT    = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_RESTART = 3'd4,
    CMD_QUERY   = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_NOT_ACTIVE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FLUSH
  } fsm_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [SlotW-1:0] timer_index;
    logic [DurW-1:0]  duration;
    logic             periodic_mode;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               fired;
    logic [SlotW-1:0]   fired_index;
    logic               running;
    logic [DurW-1:0]    remaining_ticks;
    logic               last;
  } rsp_t;

  // write controls from the command decoder to one timer cell
  typedef struct packed {
    logic init;
    logic arm;
    logic stop;
    logic per;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/software_timer_bank_unit.sv =====
// top level of the software timer bank: command decode, cell row, fire scan
//
// A request is taken at a rising edge with start_i high and busy_o low. It carries
// a command (tick, init, start, stop, restart, query), a slot index, a duration and
// a mode bit. Every result is shown on result_o for one cycle with result_valid_o
// high; the receiver cannot hold results off, and result.last marks the final one
// of a request.
// Slot commands give one result in the cycle after the request and leave busy_o
// low, so a slot command can be taken every cycle while no tick scan runs.
// A tick updates all cells at the request edge, then a token walks the row of
// cells one slot per cycle and each expired slot is reported in ascending order.
// A tick keeps busy_o high through its scan and flush states; its results
// come out during that walk, the final one in the first cycle after busy_o falls,
// one result per cycle at most.
// Reset clears every slot (inactive, one-shot, zero count and reload) and the
// scan, and no result is pending afterward.
`default_nettype none

module software_timer_bank_unit #(
  parameter int unsigned NumTimers  = stb_pkg::NumTimersDef,
  parameter int unsigned CountWidth = stb_pkg::CountWidthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire stb_pkg::req_t req_i,
  output logic               busy_o,
  output logic               result_valid_o,
  output stb_pkg::rsp_t      result_o
);

  localparam int unsigned IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int unsigned ExtW = IdxW + stb_pkg::SlotW;

  stb_pkg::fsm_e state_q, state_d;

  logic [IdxW-1:0] k_q, k_d;
  logic [IdxW-1:0] hold_q, hold_d;
  logic            hold_vld_q, hold_vld_d;
  logic            out_vld_q, out_vld_d;
  stb_pkg::rsp_t   out_q, out_d;

  logic                  accept, is_tick, tick;
  logic [ExtW-1:0]       idx_ext, k_ext, hold_ext;
  logic                  in_range;
  logic [IdxW-1:0]       sel;
  stb_pkg::cell_ctl_t    ctl;
  logic [CountWidth-1:0] arm_val, dur_sat;

  logic [NumTimers:0]    tok;
  logic [NumTimers-1:0]  hit, act_v;
  logic [CountWidth-1:0] cnt_v [NumTimers];
  logic [CountWidth-1:0] rel_v [NumTimers];

  logic                  sel_act;
  logic [CountWidth-1:0] sel_cnt, sel_rel;

  assign accept  = start_i & ~busy_o;
  assign is_tick = stb_pkg::cmd_e'(req_i.command) == stb_pkg::CMD_TICK;
  assign tick    = accept & is_tick;
  assign busy_o  = state_q != stb_pkg::FSM_IDLE;

  assign idx_ext  = {{IdxW{1'b0}}, req_i.timer_index};
  assign in_range = idx_ext < ExtW'(NumTimers);
  assign sel      = idx_ext[IdxW-1:0];
  assign k_ext    = {{stb_pkg::SlotW{1'b0}}, k_q};
  assign hold_ext = {{stb_pkg::SlotW{1'b0}}, hold_q};

  assign dur_sat = ((req_i.duration >> CountWidth) != '0) ? {CountWidth{1'b1}}
                                                          : req_i.duration[CountWidth-1:0];

  assign sel_act = act_v[sel];
  assign sel_cnt = cnt_v[sel];
  assign sel_rel = rel_v[sel];

  // row of cells, token enters at slot zero on a tick
  assign tok[0] = tick;

  for (genvar i = 0; i < NumTimers; i++) begin : g_cell
    stb_pkg::cell_ctl_t cell_ctl;
    assign cell_ctl = (sel == IdxW'(i)) ? ctl : '0;

    stb_cell #(
      .CountWidth(CountWidth)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tick_i   (tick),
      .ctl_i    (cell_ctl),
      .arm_val_i(arm_val),
      .token_i  (tok[i]),
      .token_o  (tok[i+1]),
      .hit_o    (hit[i]),
      .active_o (act_v[i]),
      .count_o  (cnt_v[i]),
      .reload_o (rel_v[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stb_pkg::FSM_IDLE: begin
        if (tick) state_d = stb_pkg::FSM_SCAN;
      end
      stb_pkg::FSM_SCAN: begin
        if (k_q == IdxW'(NumTimers - 1)) state_d = stb_pkg::FSM_FLUSH;
      end
      stb_pkg::FSM_FLUSH: begin
        state_d = stb_pkg::FSM_IDLE;
      end
      default: begin
        state_d = stb_pkg::FSM_IDLE;
      end
    endcase
  end

  // outputs, scan bookkeeping and slot command decode
  always_comb begin
    k_d        = k_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    out_vld_d  = 1'b0;
    out_d      = '0;
    ctl        = '0;
    arm_val    = dur_sat;
    case (state_q)
      stb_pkg::FSM_IDLE: begin
        k_d        = '0;
        hold_vld_d = 1'b0;
        if (accept && !is_tick) begin
          out_vld_d  = 1'b1;
          out_d.last = 1'b1;
          if (!in_range) begin
            out_d.status = stb_pkg::ST_INVALID;
          end else begin
            case (stb_pkg::cmd_e'(req_i.command))
              stb_pkg::CMD_INIT: begin
                ctl.init = 1'b1;
                ctl.per  = req_i.periodic_mode;
              end
              stb_pkg::CMD_START: begin
                if (req_i.duration == '0) begin
                  out_d.status = stb_pkg::ST_INVALID;
                end else begin
                  ctl.arm = 1'b1;
                end
              end
              stb_pkg::CMD_STOP: begin
                if (!sel_act) begin
                  out_d.status = stb_pkg::ST_NOT_ACTIVE;
                end else begin
                  ctl.stop = 1'b1;
                end
              end
              stb_pkg::CMD_RESTART: begin
                arm_val = sel_rel;
                if (sel_rel == '0) begin
                  out_d.status = stb_pkg::ST_INVALID;
                end else begin
                  ctl.arm = 1'b1;
                end
              end
              stb_pkg::CMD_QUERY: begin
                out_d.running         = sel_act;
                out_d.remaining_ticks = sel_act ? stb_pkg::DurW'(sel_cnt) : '0;
              end
              default: begin
                out_d.status = stb_pkg::ST_INVALID;
              end
            endcase
          end
        end
      end
      stb_pkg::FSM_SCAN: begin
        k_d = k_q + IdxW'(1);
        if (|hit) begin
          // a newer expiry means the held one is not the final result
          if (hold_vld_q) begin
            out_vld_d         = 1'b1;
            out_d.fired       = 1'b1;
            out_d.fired_index = hold_ext[stb_pkg::SlotW-1:0];
          end
          hold_d     = k_q;
          hold_vld_d = 1'b1;
        end
      end
      stb_pkg::FSM_FLUSH: begin
        out_vld_d  = 1'b1;
        out_d.last = 1'b1;
        if (hold_vld_q) begin
          out_d.fired       = 1'b1;
          out_d.fired_index = hold_ext[stb_pkg::SlotW-1:0];
        end
        hold_vld_d = 1'b0;
      end
      default: begin
        hold_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= stb_pkg::FSM_IDLE;
      k_q        <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  // the scan index only matters while it selects a slot
  logic unused_k;
  assign unused_k = ^k_ext[ExtW-1:stb_pkg::SlotW] ^ ^k_ext[stb_pkg::SlotW-1:0] ^ tok[NumTimers];

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/stb_cell.sv =====
// one timer slot: count, reload, flags, pending expiry and scan token stage
`default_nettype none

module stb_cell #(
  parameter int unsigned CountWidth = stb_pkg::CountWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  tick_i,
  input  wire stb_pkg::cell_ctl_t    ctl_i,
  input  wire logic [CountWidth-1:0] arm_val_i,
  input  wire logic                  token_i,
  output logic                       token_o,
  output logic                       hit_o,
  output logic                       active_o,
  output logic [CountWidth-1:0]      count_o,
  output logic [CountWidth-1:0]      reload_o
);

  logic                  act_q, act_d;
  logic                  per_q, per_d;
  logic                  pend_q, pend_d;
  logic                  tok_q;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [CountWidth-1:0] rel_q, rel_d;
  logic [CountWidth-1:0] dec;

  assign dec = (cnt_q != '0) ? cnt_q - CountWidth'(1) : cnt_q;

  always_comb begin
    act_d  = act_q;
    per_d  = per_q;
    cnt_d  = cnt_q;
    rel_d  = rel_q;
    // the token passing through clears the pending expiry
    pend_d = pend_q & ~tok_q;
    if (tick_i) begin
      if (act_q) begin
        cnt_d = dec;
        if (dec == '0) begin
          pend_d = 1'b1;
          if (per_q) begin
            cnt_d = rel_q;
          end else begin
            act_d = 1'b0;
          end
        end
      end
    end else if (ctl_i.init) begin
      per_d = ctl_i.per;
      act_d = 1'b0;
      cnt_d = '0;
      rel_d = '0;
    end else if (ctl_i.arm) begin
      rel_d = arm_val_i;
      cnt_d = arm_val_i;
      act_d = 1'b1;
    end else if (ctl_i.stop) begin
      act_d = 1'b0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      per_q  <= 1'b0;
      pend_q <= 1'b0;
      tok_q  <= 1'b0;
      cnt_q  <= '0;
      rel_q  <= '0;
    end else begin
      act_q  <= act_d;
      per_q  <= per_d;
      pend_q <= pend_d;
      tok_q  <= token_i;
      cnt_q  <= cnt_d;
      rel_q  <= rel_d;
    end
  end

  assign token_o  = tok_q;
  assign hit_o    = tok_q & pend_q;
  assign active_o = act_q;
  assign count_o  = cnt_q;
  assign reload_o = rel_q;

endmodule

`default_nettype wire
